### src/redundant_byte_store_vote_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef REDUNDANT_BYTE_STORE_VOTE_DEFINES_SVH
`define REDUNDANT_BYTE_STORE_VOTE_DEFINES_SVH

// Condition implies consequence at the same edge.
`define RBSV_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("redundant_byte_store_vote check failed");

// Condition implies consequence a given number of edges after the next one.
`define RBSV_ASSERT_LATER(lbl, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> ##dly (cons)) \
		else $error("redundant_byte_store_vote timing check failed");

`endif

### src/rbsv_pkg.sv
package rbsv_pkg;

	// Number of stored copies of every entry.
	localparam int unsigned NumCopies = 3;

	// Configuration register indexes.
	localparam logic [7:0] CfgPolynomial = 8'd0;
	localparam logic [7:0] CfgReflected  = 8'd1;

	// Command codes.
	localparam logic CmdLoad = 1'b0;
	localparam logic CmdSave = 1'b1;

	// Register reset values.
	localparam logic [7:0] PolyReset = 8'h8C;
	localparam logic       ReflReset = 1'b1;

	// CRC start value.
	localparam logic [7:0] CrcInit = 8'h00;

	// One request as it travels down the pipeline.
	typedef struct packed {
		logic                        cmd;
		logic [4:0]                  tag;
		logic [NumCopies-1:0][7:0]   val;
		logic [7:0]                  lo;
		logic [7:0]                  hi;
		logic                        pers;
		logic [7:0]                  cur;
	} req_t;

	// Outcome of the vote for one request.
	typedef struct packed {
		logic [4:0] tag;
		logic [7:0] value;
		logic       taken;
		logic [1:0] agree;
		logic [2:0] mask;
	} vote_t;

	// CRC-8 of one byte, eight shift steps in either direction.
	function automatic logic [7:0] crc8(input logic [7:0] v, input logic [7:0] poly,
			input logic refl);
		logic [7:0] r;
		r = CrcInit ^ v;
		for (int i = 0; i < 8; i++) begin
			if (refl) begin
				r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
			end else begin
				r = r[7] ? ((r << 1) ^ poly) : (r << 1);
			end
		end
		return r;
	endfunction

endpackage

### src/rbsv_crc_lane.sv
module rbsv_crc_lane (
	input  logic       clk,
	input  logic [7:0] value,
	input  logic [7:0] check,
	input  logic [7:0] poly,
	input  logic       refl,
	output logic       ok_s1
);

	// A copy is good when its stored check byte matches the recomputed CRC.
	always_ff @(posedge clk) begin
		ok_s1 <= (rbsv_pkg::crc8(value, poly, refl) == check);
	end

endmodule

### src/rbsv_vote.sv
module rbsv_vote (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              v_s1,
	input  rbsv_pkg::req_t                    req_s1,
	input  logic [rbsv_pkg::NumCopies-1:0]    ok_s1,
	output logic                              v_s2,
	output rbsv_pkg::vote_t                   res_s2
);

	logic [1:0]  cnt [rbsv_pkg::NumCopies];
	logic [1:0]  best;
	logic [7:0]  chosen;
	logic        in_range;
	rbsv_pkg::vote_t nxt;

	// Count, for each good copy, how many good copies carry the same value.
	always_comb begin
		for (int a = 0; a < rbsv_pkg::NumCopies; a++) begin
			cnt[a] = 2'd0;
			if (ok_s1[a]) begin
				for (int b = 0; b < rbsv_pkg::NumCopies; b++) begin
					if (ok_s1[b] && (req_s1.val[b] == req_s1.val[a])) begin
						cnt[a] = cnt[a] + 2'd1;
					end
				end
			end
		end
	end

	// Merge the lanes: the largest count wins and the earliest copy breaks a tie.
	always_comb begin
		best   = 2'd0;
		chosen = 8'd0;
		for (int a = 0; a < rbsv_pkg::NumCopies; a++) begin
			if (cnt[a] > best) begin
				best   = cnt[a];
				chosen = req_s1.val[a];
			end
		end
		in_range = (chosen >= req_s1.lo) && (chosen <= req_s1.hi);
	end

	// Decide the result word for the request.
	always_comb begin
		nxt.tag   = req_s1.tag;
		nxt.value = req_s1.cur;
		nxt.taken = 1'b0;
		nxt.agree = 2'd0;
		nxt.mask  = 3'd0;
		if (req_s1.pers) begin
			if (req_s1.cmd == rbsv_pkg::CmdSave) begin
				nxt.mask = 3'b111;
			end else begin
				nxt.agree = best;
				if ((best != 2'd0) && in_range) begin
					nxt.value = chosen;
					nxt.taken = 1'b1;
					for (int a = 0; a < rbsv_pkg::NumCopies; a++) begin
						nxt.mask[a] = !ok_s1[a] || (req_s1.val[a] != chosen);
					end
				end
			end
		end
	end

	// Stage two valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	// Stage two result register.
	always_ff @(posedge clk) begin
		res_s2 <= nxt;
	end

endmodule

### src/redundant_byte_store_vote.sv
// Checks three stored copies of a setting byte against their CRC-8 check bytes,
// votes among the good copies and reports which copies to rewrite. A request is
// taken on any cycle with start high; busy is always low, so one request can be
// accepted every cycle. Each result appears on the result ports for exactly one
// cycle, marked by done, after the registered stages of lane CRC check, vote
// and check byte of the result. The receiver cannot stall, so it must take every
// word in the cycle it is shown. Configuration writes are always ready and must
// only be made while no request is in flight.
module redundant_byte_store_vote (
	input  logic       clk,
	input  logic       arst_n,
	// Request channel.
	input  logic       start,
	output logic       busy,
	input  logic       cmd,
	input  logic [4:0] entry_index,
	input  logic [7:0] copy_value_a,
	input  logic [7:0] copy_value_b,
	input  logic [7:0] copy_value_c,
	input  logic [7:0] copy_check_a,
	input  logic [7:0] copy_check_b,
	input  logic [7:0] copy_check_c,
	input  logic [7:0] lower_limit,
	input  logic [7:0] upper_limit,
	input  logic       persistent,
	input  logic [7:0] current_value,
	// Configuration channel.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data,
	// Result channel.
	output logic       done,
	output logic [4:0] entry_tag,
	output logic [7:0] result_value,
	output logic       value_taken,
	output logic [1:0] agree_count,
	output logic [2:0] rewrite_mask,
	output logic [7:0] write_check
);

	logic [7:0]                      crc_poly_q;
	logic                            crc_refl_q;
	logic                            accept;
	logic                            v_s1;
	rbsv_pkg::req_t                  req_s1;
	logic [rbsv_pkg::NumCopies-1:0]  ok_s1;
	logic [rbsv_pkg::NumCopies-1:0][7:0] chk_in;
	logic [rbsv_pkg::NumCopies-1:0][7:0] val_in;
	logic                            v_s2;
	rbsv_pkg::vote_t                 res_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= rbsv_pkg::PolyReset;
			crc_refl_q <= rbsv_pkg::ReflReset;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rbsv_pkg::CfgPolynomial: crc_poly_q <= cfg_data;
					rbsv_pkg::CfgReflected: crc_refl_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// Copies laid out by lane number.
	assign val_in = {copy_value_c, copy_value_b, copy_value_a};
	assign chk_in = {copy_check_c, copy_check_b, copy_check_a};

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// Stage one request register.
	always_ff @(posedge clk) begin
		req_s1.cmd  <= cmd;
		req_s1.tag  <= entry_index;
		req_s1.val  <= val_in;
		req_s1.lo   <= lower_limit;
		req_s1.hi   <= upper_limit;
		req_s1.pers <= persistent;
		req_s1.cur  <= current_value;
	end

	// One CRC check lane per stored copy.
	for (genvar g = 0; g < rbsv_pkg::NumCopies; g++) begin : g_lane
		rbsv_crc_lane u_lane (
			.clk   (clk),
			.value (val_in[g]),
			.check (chk_in[g]),
			.poly  (crc_poly_q),
			.refl  (crc_refl_q),
			.ok_s1 (ok_s1[g])
		);
	end

	// Vote and merge of the lane results.
	rbsv_vote u_vote (
		.clk    (clk),
		.arst_n (arst_n),
		.v_s1   (v_s1),
		.req_s1 (req_s1),
		.ok_s1  (ok_s1),
		.v_s2   (v_s2),
		.res_s2 (res_s2)
	);

	// Output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s2;
		end
	end

	// Output word with the check byte of the value to hold.
	always_ff @(posedge clk) begin
		entry_tag    <= res_s2.tag;
		result_value <= res_s2.value;
		value_taken  <= res_s2.taken;
		agree_count  <= res_s2.agree;
		rewrite_mask <= res_s2.mask;
		write_check  <= rbsv_pkg::crc8(res_s2.value, crc_poly_q, crc_refl_q);
	end

endmodule

### src/rbsv_checker.sv
`include "redundant_byte_store_vote_defines.svh"

module rbsv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       value_taken,
	input logic [1:0] agree_count,
	input logic [2:0] rewrite_mask
);

	// Every accepted request is followed by the done strobe of its word.
	`RBSV_ASSERT_LATER(a_latency, start && !busy, 2, done)

	// A taken value always comes from at least one good copy.
	`RBSV_ASSERT_SAME(a_taken_agree, done && value_taken, agree_count != 2'd0)

	// The winning copy is never rewritten, so a taken value cannot rewrite all.
	`RBSV_ASSERT_SAME(a_taken_mask, done && value_taken, rewrite_mask != 3'b111)

	// Without a taken value the only rewrite is the full save.
	`RBSV_ASSERT_SAME(a_save_mask, done && !value_taken,
		rewrite_mask == 3'b000 || rewrite_mask == 3'b111)

endmodule

bind redundant_byte_store_vote rbsv_checker u_rbsv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.value_taken  (value_taken),
	.agree_count  (agree_count),
	.rewrite_mask (rewrite_mask)
);
